>>> rtl/gdt_pkg.sv
`default_nettype none
package gdt_pkg;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_FIND    = 2'd1;
   localparam logic [1:0] CMD_CLOSEST = 2'd2;

   localparam int GLYPH_W = 64;

   typedef logic [7:0] slot_type;
   typedef logic [6:0] dist_type;

   // distance seed above any real 64-bit distance
   localparam dist_type DIST_NONE = 7'd65;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [GLYPH_W-1:0] glyph;
   } req_type;

   typedef struct packed {
      slot_type slot;
      logic     found;
      logic     added;
      logic     table_full;
      dist_type hamming;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic finish;
      logic tbl_empty;
      logic tbl_full;
   } ctl_type;

endpackage
`default_nettype wire

>>> rtl/gdt_ram.sv
`default_nettype none
module gdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/gdt_datapath.sv
`default_nettype none
module gdt_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gdt_pkg::ctl_type                   ctl,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
   input  wire gdt_pkg::req_type                   req_item,
   output logic                                    append,
   output gdt_pkg::rsp_type                        rsp_item,
   output logic                                    rsp_valid
);
   import gdt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   function automatic logic [3:0] byte_ones(input logic [7:0] b);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + {3'b000, b[k]};
      end
      return n;
   endfunction

   req_type            req_ff;
   logic [GLYPH_W-1:0] rd_data;

   logic               rd_v_ff;
   logic [AW-1:0]      rd_idx_ff;

   logic               s1_v_ff;
   logic [AW-1:0]      s1_idx_ff;
   logic               s1_eq_ff;
   logic [3:0]         s1_cnt_ff [8];
   logic [3:0]         s1_cnt_in [8];

   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   dist_type           best_d_ff, best_d_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   dist_type           sum_d;

   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   gdt_ram #(
      .WIDTH(GLYPH_W),
      .DEPTH(TABLE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ctl.finish && append),
      .wr_addr(count[AW-1:0]),
      .wr_data(req_ff.glyph),
      .rd_en  (ctl.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         s1_cnt_in[b] = byte_ones(rd_data[8*b +: 8] ^ req_ff.glyph[8*b +: 8]);
      end
   end

   always_comb begin
      sum_d = '0;
      for (int b = 0; b < 8; b++) begin
         sum_d = sum_d + {3'b000, s1_cnt_ff[b]};
      end
   end

   // keep the first equal entry and the lowest index of the smallest distance
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      if (ctl.load) begin
         hit_in      = 1'b0;
         hit_idx_in  = '0;
         best_d_in   = DIST_NONE;
         best_idx_in = '0;
      end else if (s1_v_ff) begin
         if (s1_eq_ff && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = s1_idx_ff;
         end
         if (sum_d < best_d_ff) begin
            best_d_in   = sum_d;
            best_idx_in = s1_idx_ff;
         end
      end
   end

   assign append = (req_ff.cmd == CMD_INSERT) && !hit_ff && !ctl.tbl_full;

   always_comb begin
      rsp_in = '0;
      case (req_ff.cmd)
         CMD_INSERT: begin
            if (hit_ff) begin
               rsp_in.slot  = slot_type'(hit_idx_ff);
               rsp_in.found = 1'b1;
            end else if (!ctl.tbl_full) begin
               rsp_in.slot  = slot_type'(count);
               rsp_in.added = 1'b1;
            end else begin
               rsp_in.table_full = 1'b1;
            end
         end
         CMD_FIND: begin
            if (hit_ff) begin
               rsp_in.slot  = slot_type'(hit_idx_ff);
               rsp_in.found = 1'b1;
            end
         end
         CMD_CLOSEST: begin
            if (!ctl.tbl_empty) begin
               rsp_in.slot    = slot_type'(best_idx_ff);
               rsp_in.found   = 1'b1;
               rsp_in.hamming = best_d_ff;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_item;
      end
      rd_idx_ff   <= rd_addr;
      s1_idx_ff   <= rd_idx_ff;
      s1_eq_ff    <= (rd_data == req_ff.glyph);
      s1_cnt_ff   <= s1_cnt_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         rd_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff      <= ctl.rd_en;
         s1_v_ff      <= rd_v_ff;
         rsp_valid_ff <= ctl.finish;
      end
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> rtl/gdt_ctrl.sv
`default_nettype none
module gdt_ctrl #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic                               append,
   output logic                                    busy,
   output gdt_pkg::ctl_type                        ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0]          rd_addr,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]        count
);
   import gdt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN0,
      S_DRAIN1,
      S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          accept;
   logic          last;

   assign accept = start && !busy_ff;
   assign last   = (CW'(addr_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               busy_in  = 1'b1;
               addr_in  = '0;
               state_in = (count_ff == '0) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            if (last) begin
               state_in = S_DRAIN0;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         // let the last read pass the compare stages
         S_DRAIN0: state_in = S_DRAIN1;
         S_DRAIN1: state_in = S_FINISH;
         S_FINISH: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
            if (append) begin
               count_in = count_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         addr_ff  <= '0;
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_comb begin
      ctl.load      = accept;
      ctl.rd_en     = (state_ff == S_SCAN);
      ctl.finish    = (state_ff == S_FINISH);
      ctl.tbl_empty = (count_ff == '0);
      ctl.tbl_full  = (count_ff == CW'(TABLE_DEPTH));
   end

   assign busy    = busy_ff;
   assign rd_addr = addr_ff;
   assign count   = count_ff;

endmodule
`default_nettype wire

>>> rtl/glyph_dedup_table_nearest_match.sv
`default_nettype none
// Glyph table with insert, exact find and nearest (Hamming) find over up to
// TABLE_DEPTH 64-bit glyphs. A request is taken when start is high and busy is
// low; its single response appears on rsp_item for one cycle with rsp_valid
// high and cannot be held off, so capture it then. Every request walks the
// stored entries one per cycle through the single read port of the glyph RAM,
// followed by two compare stages and a result state; an empty table goes
// straight to the result state. busy drops in the cycle the response is
// shown, so the next request may be given in that same cycle.
module glyph_dedup_table_nearest_match #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire gdt_pkg::req_type req_item,
   output gdt_pkg::rsp_type      rsp_item,
   output logic                  rsp_valid
);
   import gdt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   ctl_type       ctl;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] count;
   logic          append;

   gdt_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .append (append),
      .busy   (busy),
      .ctl    (ctl),
      .rd_addr(rd_addr),
      .count  (count)
   );

   gdt_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .count    (count),
      .req_item (req_item),
      .append   (append),
      .rsp_item (rsp_item),
      .rsp_valid(rsp_valid)
   );

   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_item.found, rsp_item.added, rsp_item.table_full}) <= 1)
      else $error("conflicting response flags");

endmodule
`default_nettype wire
